[src/assert_macros.svh]
// Assertion macros shared by the voxel table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[src/vht_pkg.sv]
// Types and constants shared by the voxel hash table modules.
package vht_pkg;

    localparam int COORD_BITS = 16;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [31:0] BASE_FRAC = 32'h9E3779B6;
    localparam logic [31:0] STEP_FRAC = 32'hB504F333;

    localparam logic [4:0] MIN_LOG2  = 5'd3;
    localparam logic [4:0] CFG_RESET = 5'd16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] voxel_x;
        logic signed [COORD_BITS-1:0] voxel_y;
        logic signed [COORD_BITS-1:0] voxel_z;
        logic signed [31:0]           pos_x;
        logic signed [31:0]           pos_y;
        logic signed [31:0]           pos_z;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
    } vht_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        slot;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [16:0]        occupancy;
    } vht_rsp_t;

    typedef struct packed {
        logic clr_write;
        logic load;
        logic hash_step;
        logic abs_key;
        logic mul_base;
        logic mul_step;
        logic take_step;
        logic read;
        logic advance;
        logic finish;
    } vht_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic probe_done;
    } vht_stat_t;

endpackage

[src/vht_ctrl.sv]
// Sequencing state machine for the voxel hash table.
`include "assert_macros.svh"

module vht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  vht_pkg::vht_stat_t stat,
    output logic              busy,
    output vht_pkg::vht_cmd_t cmd
);
    import vht_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_ABS   = 4'd3;
    localparam logic [3:0] S_MULB  = 4'd4;
    localparam logic [3:0] S_MULS  = 4'd5;
    localparam logic [3:0] S_STEP  = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                cmd.abs_key = 1'b1;
                state_next  = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_base = 1'b1;
                state_next   = S_MULS;
            end
            S_MULS:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                cmd.take_step = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.probe_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))
    `ASSERT_NEXT(a_probe_loop, clk, rst_n, (state_reg == S_CHECK) && !stat.probe_done, state_reg == S_READ)

endmodule

[src/vht_dpath.sv]
// Hashing, probing and table storage for the voxel hash table.
`include "assert_macros.svh"

module vht_dpath #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_data,
    input  vht_pkg::vht_req_t request,
    input  vht_pkg::vht_cmd_t cmd,
    output vht_pkg::vht_stat_t stat,
    output logic              done,
    output vht_pkg::vht_rsp_t result
);
    import vht_pkg::*;

    localparam int         ADDR_W = $clog2(TABLE_DEPTH);
    localparam int         CNT_W  = ADDR_W + 1;
    localparam logic [4:0] MAX_L  = 5'(ADDR_W);

    typedef struct packed {
        logic                      occ;
        logic [3*COORD_BITS-1:0]   key;
        logic [31:0]               px;
        logic [31:0]               py;
        logic [31:0]               pz;
        logic [23:0]               color;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];

    logic [4:0]        cfg_reg;
    vht_req_t          req_reg;
    logic [31:0]       hash_reg;
    logic [1:0]        idx_reg;
    logic [31:0]       prod_reg;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] step_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    entry_t            rd_reg;
    vht_rsp_t          rsp_reg;
    logic              done_reg;

    logic [4:0]        eff_l;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] top_bits;
    logic [31:0]       coord_sel;
    logic [31:0]       hash_next;
    logic [31:0]       prod_next;
    logic [ADDR_W-1:0] j_next;
    logic [3*COORD_BITS-1:0] req_key;
    logic              match;
    logic              ins;
    logic [CNT_W-1:0]  count_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    vht_rsp_t          rsp_next;

    always_comb
    begin
        if (cfg_reg < MIN_LOG2)
        begin
            eff_l = MIN_LOG2;
        end
        else if (cfg_reg > MAX_L)
        begin
            eff_l = MAX_L;
        end
        else
        begin
            eff_l = cfg_reg;
        end
    end

    assign mask     = {ADDR_W{1'b1}} >> (MAX_L - eff_l);
    assign top_bits = ADDR_W'(prod_reg >> (6'd32 - {1'b0, eff_l}));

    always_comb
    begin
        case (idx_reg)
            2'd0:    coord_sel = 32'(req_reg.voxel_x);
            2'd1:    coord_sel = 32'(req_reg.voxel_y);
            default: coord_sel = 32'(req_reg.voxel_z);
        endcase
    end

    assign hash_next = (hash_reg << 5) + hash_reg + coord_sel;
    assign prod_next = hash_reg * (cmd.mul_step ? STEP_FRAC : BASE_FRAC);
    assign j_next    = (j_reg + step_reg) & mask;

    assign req_key    = {req_reg.voxel_x, req_reg.voxel_y, req_reg.voxel_z};
    assign match      = rd_reg.occ && (rd_reg.key == req_key);
    assign ins        = !rd_reg.occ && (req_reg.command == CMD_INSERT);
    assign count_next = count_reg + CNT_W'(ins);

    assign stat.clr_last   = (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign stat.hash_last  = (idx_reg == 2'd2);
    assign stat.probe_done = !rd_reg.occ || match || (k_reg == mask);

    always_comb
    begin
        mem_wdata.occ   = 1'b1;
        mem_wdata.key   = req_key;
        mem_wdata.px    = req_reg.pos_x;
        mem_wdata.py    = req_reg.pos_y;
        mem_wdata.pz    = req_reg.pos_z;
        mem_wdata.color = {req_reg.red, req_reg.green, req_reg.blue};
        mem_waddr       = j_reg;
        mem_we          = cmd.finish && ins;
        if (cmd.clr_write)
        begin
            mem_wdata = '0;
            mem_waddr = clr_addr_reg;
            mem_we    = 1'b1;
        end
    end

    always_comb
    begin
        rsp_next           = '0;
        rsp_next.occupancy = 17'(count_next);
        if (match)
        begin
            rsp_next.status    = (req_reg.command == CMD_FIND) ? ST_FOUND : ST_PRESENT;
            rsp_next.slot      = 16'(j_reg);
            rsp_next.out_pos_x = rd_reg.px;
            rsp_next.out_pos_y = rd_reg.py;
            rsp_next.out_pos_z = rd_reg.pz;
            rsp_next.out_red   = rd_reg.color[23:16];
            rsp_next.out_green = rd_reg.color[15:8];
            rsp_next.out_blue  = rd_reg.color[7:0];
        end
        else if (ins)
        begin
            rsp_next.status    = ST_INSERTED;
            rsp_next.slot      = 16'(j_reg);
            rsp_next.out_pos_x = req_reg.pos_x;
            rsp_next.out_pos_y = req_reg.pos_y;
            rsp_next.out_pos_z = req_reg.pos_z;
            rsp_next.out_red   = req_reg.red;
            rsp_next.out_green = req_reg.green;
            rsp_next.out_blue  = req_reg.blue;
        end
        else
        begin
            rsp_next.status = (req_reg.command == CMD_FIND) ? ST_NOT_FOUND : ST_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rd_reg <= entry_t'(entry_mem[j_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= CFG_RESET;
            count_reg    <= '0;
            clr_addr_reg <= '0;
            idx_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= request;
            hash_reg <= HASH_SEED;
        end
        if (cmd.hash_step)
        begin
            hash_reg <= hash_next;
        end
        if (cmd.abs_key && hash_reg[31])
        begin
            hash_reg <= 32'd0 - hash_reg;
        end
        if (cmd.mul_base || cmd.mul_step)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_step)
        begin
            j_reg <= top_bits;
        end
        if (cmd.take_step)
        begin
            step_reg <= top_bits | ADDR_W'(1);
            k_reg    <= '0;
        end
        if (cmd.advance)
        begin
            j_reg <= j_next;
            k_reg <= k_reg + ADDR_W'(1);
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    `ASSERT_ALWAYS(a_done_follows_finish, clk, rst_n, done_reg == $past(cmd.finish))
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(TABLE_DEPTH))
    `ASSERT_IMPL(a_slot_in_range, clk, rst_n, cmd.finish, (j_reg & ~mask) == '0)

endmodule

[src/voxel_hash_table_double_hashing_core.sv]
// Top level of the voxel hash table with double-hashed probing.
//
//  channel  | ports                 | transfer
//  ---------+-----------------------+------------------------------------
//  config   | cfg_we, cfg_data      | cfg_we high at a rising edge
//  request  | start, busy, request  | start high and busy low at an edge
//  result   | done, result          | done high for one cycle, no stall
//
// A command passes the hash, absolute value, two multiply and step states, then
// a loop of table probes; each probe is a memory read and a compare.
// The result is shown for one cycle right after the last probe.
// After reset the table memory is cleared one slot per cycle, and busy stays
// high until every slot is clear; configuration writes are taken meanwhile.
// The receiver cannot stall, and a new command may start while a result shows.
module voxel_hash_table_double_hashing_core #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_data,
    input  logic              start,
    input  vht_pkg::vht_req_t request,
    output logic              busy,
    output logic              done,
    output vht_pkg::vht_rsp_t result
);
    import vht_pkg::*;

    vht_cmd_t  cmd;
    vht_stat_t stat;

    vht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    vht_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .request  (request),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

[tb/voxel_hash_table_double_hashing_core_tb.sv]
// Self-checking testbench for the voxel hash table core, checked against a behavioural table model.
module voxel_hash_table_double_hashing_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vht_pkg::*;

    localparam int TABLE_DEPTH = 65536;
    localparam int DEPTH_LOG2  = $clog2(TABLE_DEPTH);
    localparam int VOXEL_BITS  = 3 * COORD_BITS;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     cfg_we   = 1'b0;
    logic [4:0] cfg_data = '0;
    logic     start    = 1'b0;
    vht_req_t request  = '0;
    logic     busy;
    logic     done;
    vht_rsp_t result;

    logic [4:0]            size_log2_shadow = CFG_RESET;
    bit                    slot_used [TABLE_DEPTH];
    logic [VOXEL_BITS-1:0] slot_voxel [TABLE_DEPTH];
    logic [31:0]           slot_px [TABLE_DEPTH];
    logic [31:0]           slot_py [TABLE_DEPTH];
    logic [31:0]           slot_pz [TABLE_DEPTH];
    logic [23:0]           slot_rgb [TABLE_DEPTH];
    logic [16:0]           entries_held = '0;

    vht_rsp_t              pending_results [$];
    logic [VOXEL_BITS-1:0] known_voxels [$];
    int                    errors  = 0;
    bit                    gaps_on = 1'b1;

    voxel_hash_table_double_hashing_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] widen_coord(input logic [COORD_BITS-1:0] v);
        return {{(32 - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic vht_rsp_t predict_outcome(input vht_req_t req);
        vht_rsp_t              rsp;
        logic [VOXEL_BITS-1:0] voxel;
        logic [31:0]           h;
        logic [63:0]           prod;
        int unsigned           l;
        int unsigned           size;
        int unsigned           j;
        int unsigned           stride;
        int unsigned           s;
        int unsigned           k;
        int                    hit;
        int                    hole;
        rsp   = '0;
        voxel = {req.voxel_x, req.voxel_y, req.voxel_z};
        l = size_log2_shadow;
        if (l < MIN_LOG2)
            l = MIN_LOG2;
        if (l > DEPTH_LOG2)
            l = DEPTH_LOG2;
        size = 1 << l;
        h = HASH_SEED;
        h = h * 32'd33 + widen_coord(req.voxel_x);
        h = h * 32'd33 + widen_coord(req.voxel_y);
        h = h * 32'd33 + widen_coord(req.voxel_z);
        if (h[31])
            h = -h;
        prod   = {32'd0, h} * {32'd0, BASE_FRAC};
        j      = prod[31:0] >> (32 - l);
        prod   = {32'd0, h} * {32'd0, STEP_FRAC};
        stride = (prod[31:0] >> (32 - l)) | 1;
        hit  = -1;
        hole = -1;
        for (k = 0; k < size; k++)
        begin
            s = j & (size - 1);
            if (!slot_used[s])
            begin
                hole = s;
                break;
            end
            if (slot_voxel[s] == voxel)
            begin
                hit = s;
                break;
            end
            j = (s + stride) & (size - 1);
        end
        if (hit >= 0)
            rsp.status = (req.command == CMD_FIND) ? ST_FOUND : ST_PRESENT;
        else if (req.command == CMD_FIND)
            rsp.status = ST_NOT_FOUND;
        else if (hole >= 0)
        begin
            slot_used[hole]  = 1'b1;
            slot_voxel[hole] = voxel;
            slot_px[hole]    = req.pos_x;
            slot_py[hole]    = req.pos_y;
            slot_pz[hole]    = req.pos_z;
            slot_rgb[hole]   = {req.red, req.green, req.blue};
            entries_held++;
            hit = hole;
            rsp.status = ST_INSERTED;
        end
        else
            rsp.status = ST_FULL;
        if (hit >= 0)
        begin
            rsp.slot      = 16'(hit);
            rsp.out_pos_x = slot_px[hit];
            rsp.out_pos_y = slot_py[hit];
            rsp.out_pos_z = slot_pz[hit];
            {rsp.out_red, rsp.out_green, rsp.out_blue} = slot_rgb[hit];
        end
        rsp.occupancy = entries_held;
        return rsp;
    endfunction

    function automatic vht_req_t make_request(input logic cmd, input int x, input int y,
                                              input int z, input logic [31:0] px,
                                              input logic [31:0] py, input logic [31:0] pz,
                                              input logic [23:0] rgb);
        vht_req_t req;
        req.command = cmd;
        req.voxel_x = COORD_BITS'(x);
        req.voxel_y = COORD_BITS'(y);
        req.voxel_z = COORD_BITS'(z);
        req.pos_x   = px;
        req.pos_y   = py;
        req.pos_z   = pz;
        {req.red, req.green, req.blue} = rgb;
        return req;
    endfunction

    function automatic vht_req_t random_request();
        vht_req_t              req;
        logic [VOXEL_BITS-1:0] voxel;
        req.command = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_FIND;
        if (known_voxels.size() != 0 && $urandom_range(99) < 50)
            voxel = known_voxels[$urandom_range(known_voxels.size() - 1)];
        else
        begin
            if ($urandom_range(1) == 0)
                voxel = VOXEL_BITS'({$urandom, $urandom});
            else
                voxel = {COORD_BITS'($urandom_range(16)) - COORD_BITS'(8),
                         COORD_BITS'($urandom_range(16)) - COORD_BITS'(8),
                         COORD_BITS'($urandom_range(16)) - COORD_BITS'(8)};
            known_voxels.insert(known_voxels.size(), voxel);
        end
        {req.voxel_x, req.voxel_y, req.voxel_z} = voxel;
        req.pos_x = $urandom;
        req.pos_y = $urandom;
        req.pos_z = $urandom;
        req.red   = 8'($urandom);
        req.green = 8'($urandom);
        req.blue  = 8'($urandom);
        return req;
    endfunction

    task automatic send_request(input vht_req_t req);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        // The transfer takes place at the first edge where busy is low.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_outcome(req));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [4:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_log2_shadow = value;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        vht_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no transfer outstanding, expected none, actual %p",
                         $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, result.status);
                compare_field("slot", want.slot, result.slot);
                compare_field("out_pos_x", want.out_pos_x, result.out_pos_x);
                compare_field("out_pos_y", want.out_pos_y, result.out_pos_y);
                compare_field("out_pos_z", want.out_pos_z, result.out_pos_z);
                compare_field("out_red", want.out_red, result.out_red);
                compare_field("out_green", want.out_green, result.out_green);
                compare_field("out_blue", want.out_blue, result.out_blue);
                compare_field("occupancy", want.occupancy, result.occupancy);
            end
        end
    end

    task automatic test_basic_commands();
        write_size(5'd16);
        send_request(make_request(CMD_INSERT, -32768, -32768, -32768,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h000000));
        send_request(make_request(CMD_INSERT, 32767, 32767, 32767,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF));
        send_request(make_request(CMD_INSERT, 0, 0, 0,
                                  32'h0001_8000, 32'hFFFF_0000, 32'h0000_0000, 24'hA55A0F));
        send_request(make_request(CMD_FIND, -32768, -32768, -32768, '0, '0, '0, '0));
        send_request(make_request(CMD_FIND, 32767, 32767, 32767, '0, '0, '0, '0));
        send_request(make_request(CMD_INSERT, -32768, -32768, -32768,
                                  32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 24'h123456));
        send_request(make_request(CMD_FIND, 1, 2, 3, 32'hFFFF_FFFF, '0, '0, 24'hFFFFFF));
        send_request(make_request(CMD_INSERT, -1, 0, 1,
                                  32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_0001, 24'h00FF00));
        send_request(make_request(CMD_FIND, -1, 0, 1, '0, '0, '0, '0));
        send_request(make_request(CMD_FIND, 0, 0, 0, '0, '0, '0, '0));
    endtask

    task automatic test_table_full();
        wait_idle();
        write_size(5'd0);
        for (int i = 1; i <= 10; i++)
            send_request(make_request(CMD_INSERT, i, -i, 2 * i, $urandom, $urandom, $urandom,
                                      24'($urandom)));
        send_request(make_request(CMD_FIND, 100, 100, 100, '0, '0, '0, '0));
        send_request(make_request(CMD_FIND, 1, -1, 2, '0, '0, '0, '0));
        send_request(make_request(CMD_INSERT, 1, -1, 2, $urandom, $urandom, $urandom,
                                  24'($urandom)));
    endtask

    task automatic test_size_clamp();
        wait_idle();
        write_size(5'd31);
        send_request(make_request(CMD_FIND, -32768, -32768, -32768, '0, '0, '0, '0));
        send_request(make_request(CMD_FIND, 32767, 32767, 32767, '0, '0, '0, '0));
        send_request(make_request(CMD_INSERT, 5, 5, 5, $urandom, $urandom, $urandom,
                                  24'($urandom)));
    endtask

    task automatic run_random_phase(input logic [4:0] size_value, input int count,
                                    input bit with_gaps);
        wait_idle();
        write_size(size_value);
        gaps_on = with_gaps;
        repeat (count)
            send_request(random_request());
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 200, 1'b1);
        run_random_phase(5'd5, 80, 1'b1);
        run_random_phase(5'd20, 150, 1'b0);
        run_random_phase(5'd10, 120, 1'b1);
        run_random_phase(5'd2, 40, 1'b1);
        run_random_phase(5'd12, 60, 1'b1);
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        test_basic_commands();
        test_table_full();
        test_size_clamp();
        test_random_traffic();
        wait_idle();
        repeat (40)
            @(posedge clk);
        errors += pending_results.size();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
